// ===== sv/csilp_pkg.sv =====
// Shared types and constants for the command stream inline load parser.
package csilp_pkg;

  // Sizing of the capture limits
  localparam int LOAD_LIMIT = 16;
  localparam int MAX_DWORDS = 256;

  localparam int CNT_W  = 13;   // header count / payload index width
  localparam int LCNT_W = 5;    // load counter width

  localparam logic [CNT_W-1:0] MAX_PAYLOAD_RST = CNT_W'(200);

  // Header fields
  localparam logic [2:0]  OPC_MIN = 3'd1;
  localparam logic [2:0]  OPC_MAX = 3'd4;
  localparam logic [15:0] MTH_ADDR = 16'h2062;
  localparam logic [15:0] MTH_SIZE = 16'h2060;
  localparam logic [15:0] MTH_LOAD = 16'h206d;

  // Payload handling of the current header
  localparam logic [1:0] MODE_SKIP = 2'd0;
  localparam logic [1:0] MODE_ADDR = 2'd1;
  localparam logic [1:0] MODE_SIZE = 2'd2;
  localparam logic [1:0] MODE_CAP  = 2'd3;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [3:0]        load_number;
    logic [63:0]       addr;
    logic [31:0]       size;
    logic [31:0]       slot;
    logic [7:0]        pos;
    logic [31:0]       word;
    logic              last;
    logic [LCNT_W-1:0] found;
  } res_t;

  // Results produced by one input beat, oldest in r0
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== sv/csilp_parse.sv =====
// Parser state and per-word result generation.
module csilp_parse import csilp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             beat,
  input  logic [31:0]      word,
  input  logic             region,
  input  logic             final_word,
  output push_t            push
);

  logic [CNT_W-1:0]  max_r;
  logic [63:0]       addr_r, addr_nxt;
  logic [31:0]       high_r, high_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [31:0]       slot_r, slot_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [LCNT_W-1:0] lcnt_r, lcnt_nxt;
  logic              done_r, done_nxt;

  logic [2:0]        opc;
  logic [CNT_W-1:0]  hcnt;
  logic [15:0]       mth;
  logic              hdr_ok;
  logic              pay_vld, sum_vld;
  res_t              pay, sum;

  assign opc  = word[31:29];
  assign hcnt = word[28:16];
  assign mth  = word[15:0];
  assign hdr_ok = (opc >= OPC_MIN) && (opc <= OPC_MAX) &&
                  (hcnt != '0) && (hcnt <= max_r);

  // Next state and results for the accepted word
  always_comb begin
    addr_nxt = addr_r;
    high_nxt = high_r;
    size_nxt = size_r;
    slot_nxt = slot_r;
    rem_nxt  = rem_r;
    mode_nxt = mode_r;
    idx_nxt  = idx_r;
    lcnt_nxt = lcnt_r;
    done_nxt = done_r;
    pay_vld  = 1'b0;
    sum_vld  = 1'b0;
    pay      = '0;

    if (beat && !done_r) begin
      if (rem_r != '0) begin
        // payload word of an accepted header
        case (mode_r)
          MODE_ADDR: begin
            if (idx_r == CNT_W'(0)) begin
              high_nxt = word;
            end else if (idx_r == CNT_W'(1)) begin
              addr_nxt = {high_r, word};
            end
          end
          MODE_SIZE: begin
            if (idx_r == CNT_W'(0)) begin
              high_nxt = word;
            end else if (idx_r == CNT_W'(1)) begin
              size_nxt = high_r;
              slot_nxt = word;
            end
          end
          MODE_CAP: begin
            if ({1'b0, idx_r} < (CNT_W+1)'(MAX_DWORDS)) begin
              pay_vld = 1'b1;
            end
          end
          default: ;
        endcase
        pay.kind        = KIND_PAYLOAD;
        pay.load_number = 4'(lcnt_r - LCNT_W'(1));
        pay.addr        = addr_r;
        pay.size        = size_r;
        pay.slot        = slot_r;
        pay.pos         = idx_r[7:0];
        pay.word        = word;
        pay.last        = (rem_r == CNT_W'(1)) ||
                          ({1'b0, idx_r} == (CNT_W+1)'(MAX_DWORDS - 1)) || final_word;
        idx_nxt = idx_r + CNT_W'(1);
        rem_nxt = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          mode_nxt = MODE_SKIP;
          idx_nxt  = '0;
        end
        if (final_word) begin
          sum_vld  = 1'b1;
          done_nxt = 1'b1;
        end
      end else if (!region) begin
        // region ended while a header was expected
        sum_vld  = 1'b1;
        done_nxt = 1'b1;
      end else begin
        // header decode
        if (hdr_ok) begin
          rem_nxt  = hcnt;
          idx_nxt  = '0;
          mode_nxt = MODE_SKIP;
          if (mth == MTH_ADDR && hcnt >= CNT_W'(2)) begin
            mode_nxt = MODE_ADDR;
          end else if (mth == MTH_SIZE && hcnt >= CNT_W'(2)) begin
            mode_nxt = MODE_SIZE;
          end else if (mth == MTH_LOAD && lcnt_r < LCNT_W'(LOAD_LIMIT)) begin
            mode_nxt = MODE_CAP;
            lcnt_nxt = lcnt_r + LCNT_W'(1);
          end
        end
        if (final_word) begin
          sum_vld  = 1'b1;
          done_nxt = 1'b1;
        end
      end
    end
  end

  // End summary carries only the load count
  always_comb begin
    sum       = '0;
    sum.kind  = KIND_SUMMARY;
    sum.found = lcnt_nxt;
  end

  // Order results, payload first
  always_comb begin
    push = '0;
    if (pay_vld) begin
      push.r0  = pay;
      push.r1  = sum;
      push.cnt = sum_vld ? 2'd2 : 2'd1;
    end else if (sum_vld) begin
      push.r0  = sum;
      push.cnt = 2'd1;
    end
  end

  // Control and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= MAX_PAYLOAD_RST;
      addr_r <= '0;
      high_r <= '0;
      size_r <= '0;
      slot_r <= '0;
      rem_r  <= '0;
      mode_r <= MODE_SKIP;
      idx_r  <= '0;
      lcnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      addr_r <= addr_nxt;
      high_r <= high_nxt;
      size_r <= size_nxt;
      slot_r <= slot_nxt;
      rem_r  <= rem_nxt;
      mode_r <= mode_nxt;
      idx_r  <= idx_nxt;
      lcnt_r <= lcnt_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

// ===== sv/csilp_obuf.sv =====
// Three-entry result queue that takes up to two results per cycle.
module csilp_obuf import csilp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_vld,
  input  logic  out_rdy,
  output res_t  out_res
);

  res_t       ent_r [3];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] wp_p1;
  logic       pop;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign room    = (cnt_r <= 2'd1);
  assign out_vld = (cnt_r != 2'd0);
  assign out_res = ent_r[rp_r];
  assign pop     = out_vld && out_rdy;
  assign wp_p1   = inc3(wp_r);

  // Pointer and fill updates
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = pop ? inc3(rp_r) : rp_r;
    cnt_nxt = cnt_r + push.cnt - {1'b0, pop};
    case (push.cnt)
      2'd1:    wp_nxt = wp_p1;
      2'd2:    wp_nxt = inc3(wp_p1);
      default: wp_nxt = wp_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent_r[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      ent_r[wp_p1] <= push.r1;
    end
  end

endmodule

// ===== sv/command_stream_inline_load_parser_core.sv =====
// Top level of the command stream inline load parser.
//
// Input channel in_*: one 32-bit command ring word per beat, in_tuser marks
// words inside the changed region, in_tlast marks the last ring word.
// Output channel out_*: payload words of captured inline loads, tagged with
// the latched buffer address, size and slot, and one end summary beat
// (out_tuser high) that carries the number of loads found.
// cfg_we/cfg_wdata write the largest accepted header payload count.
//
// Each accepted word is decoded in the cycle it arrives and its results are
// written into a three-entry output queue, so a result can appear on the
// output no earlier than the cycle after its word. One word per cycle is taken
// while the queue holds at most one result; the input stalls after a word that
// gives two results (payload plus summary), and otherwise only while the queue
// holds two or more results because the receiver stalls.
// Reset returns the parser to expecting a header with all latches cleared,
// the count limit at 200 and the queue empty. After the summary the block
// keeps taking words and produces nothing until the next reset.
module command_stream_inline_load_parser_core import csilp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  // configuration
  input  logic          cfg_we,
  input  logic [12:0]   cfg_wdata,   // max_payload_count
  // input words
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,    // stream_word
  input  logic          in_tuser,    // in_region
  input  logic          in_tlast,    // final_word
  // results
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [183:0]  out_tdata,   // load_number[3:0], buffer_address[67:4],
                                     // buffer_size[99:68], buffer_slot[131:100],
                                     // word_position[139:132], payload_word[171:140],
                                     // loads_found[176:172], zero fill[183:177]
  output logic          out_tuser,   // result_kind
  output logic          out_tlast    // last_of_load
);

  push_t push;
  res_t  res;
  logic  room;

  assign in_tready = room;

  csilp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .beat       (in_tvalid && room),
    .word       (in_tdata),
    .region     (in_tuser),
    .final_word (in_tlast),
    .push       (push)
  );

  csilp_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_res (res)
  );

  // Pack result fields onto the stream
  assign out_tdata = {7'd0, res.found, res.word, res.pos, res.slot, res.size,
                      res.addr, res.load_number};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== sv/csilp_checker.sv =====
// Port-level checks for the parser core, bound to the top level.
module csilp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [183:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tlast
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Nothing follows the summary beat
  a_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser |=> !out_tvalid)
    else $error("result after end summary");

  // Payload beats carry no load count
  a_pay_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[176:172] == 5'd0)
    else $error("load count on payload beat");

  // Summary beats carry only the load count
  a_sum_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast && out_tdata[171:0] == '0)
    else $error("summary beat has payload fields set");

endmodule

bind command_stream_inline_load_parser_core csilp_checker u_csilp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/command_stream_inline_load_parser_core_test.sv =====
// Self-checking testbench for the command stream inline load parser core.
import csilp_pkg::*;

// Tracks parser state per accepted word and holds the result beats still due
class load_beat_scoreboard;
  int unsigned limit;
  logic [63:0] buf_addr;
  logic [31:0] hi_word;
  logic [31:0] buf_size;
  logic [31:0] buf_slot;
  int unsigned words_left;
  int unsigned idx;
  int unsigned loads;
  logic [1:0]  mode;
  bit          done;
  int          mismatches;
  res_t        due_beats[$];

  function new();
    limit      = 32'(MAX_PAYLOAD_RST);
    buf_addr   = '0;
    hi_word    = '0;
    buf_size   = '0;
    buf_slot   = '0;
    words_left = 0;
    idx        = 0;
    loads      = 0;
    mode       = MODE_SKIP;
    done       = 1'b0;
    mismatches = 0;
  endfunction

  function void push_summary();
    res_t r;
    r       = '0;
    r.kind  = KIND_SUMMARY;
    r.found = LCNT_W'(loads);
    due_beats.push_back(r);
    done = 1'b1;
  endfunction

  // Advance the parser by one accepted word
  function void take_word(logic [31:0] w, logic region, logic fin);
    logic [2:0]  opc;
    logic [12:0] cnt;
    logic [15:0] mth;
    int unsigned cap_len;
    res_t        r;
    if (done) return;
    if (words_left > 0) begin
      case (mode)
        MODE_ADDR: begin
          if (idx == 0) hi_word = w;
          else if (idx == 1) buf_addr = {hi_word, w};
        end
        MODE_SIZE: begin
          if (idx == 0) hi_word = w;
          else if (idx == 1) begin
            buf_size = hi_word;
            buf_slot = w;
          end
        end
        MODE_CAP: begin
          // only the first MAX_DWORDS words of a load are emitted
          cap_len = (idx + words_left < MAX_DWORDS) ? idx + words_left : MAX_DWORDS;
          if (idx < cap_len) begin
            r             = '0;
            r.kind        = KIND_PAYLOAD;
            r.load_number = 4'(loads - 1);
            r.addr        = buf_addr;
            r.size        = buf_size;
            r.slot        = buf_slot;
            r.pos         = 8'(idx);
            r.word        = w;
            r.last        = (idx + 1 == cap_len) || fin;
            due_beats.push_back(r);
          end
        end
        default: ;
      endcase
      idx = (idx + 1) & 32'h1FFF;
      words_left--;
      if (words_left == 0) begin
        mode = MODE_SKIP;
        idx  = 0;
      end
    end else if (!region) begin
      // end of the changed region while a header is due
      push_summary();
      return;
    end else begin
      opc = w[31:29];
      cnt = w[28:16];
      mth = w[15:0];
      if (opc >= OPC_MIN && opc <= OPC_MAX && cnt != 0 && cnt <= limit) begin
        words_left = 32'(cnt);
        idx        = 0;
        mode       = MODE_SKIP;
        if (mth == MTH_ADDR && cnt >= 2) mode = MODE_ADDR;
        else if (mth == MTH_SIZE && cnt >= 2) mode = MODE_SIZE;
        else if (mth == MTH_LOAD && loads < LOAD_LIMIT) begin
          mode = MODE_CAP;
          loads++;
        end
      end
    end
    if (fin) push_summary();
  endfunction

  function void cmp(string fld, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fld, want, got);
      mismatches++;
    end
  endfunction

  // Compare one output beat with the oldest beat due
  function void match_beat(logic kind, logic [183:0] d, logic last);
    res_t e;
    if (due_beats.size() == 0) begin
      $display("%0t: unexpected beat: expected none, actual kind %0b data %h last %0b",
               $time, kind, d, last);
      mismatches++;
      return;
    end
    e = due_beats.pop_front();
    cmp("result_kind", e.kind, kind);
    cmp("load_number", e.load_number, d[3:0]);
    cmp("buffer_address", e.addr, d[67:4]);
    cmp("buffer_size", e.size, d[99:68]);
    cmp("buffer_slot", e.slot, d[131:100]);
    cmp("word_position", e.pos, d[139:132]);
    cmp("payload_word", e.word, d[171:140]);
    cmp("last_of_load", e.last, last);
    cmp("loads_found", e.found, d[176:172]);
    cmp("zero_fill", '0, d[183:177]);
  endfunction
endclass

module command_stream_inline_load_parser_core_test;
  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [12:0]   cfg_wdata;
  logic          in_tvalid;
  logic          in_tready;
  logic [31:0]   in_tdata;
  logic          in_tuser;
  logic          in_tlast;
  logic          out_tvalid;
  logic          out_tready;
  logic [183:0]  out_tdata;
  logic          out_tuser;
  logic          out_tlast;

  load_beat_scoreboard sb;

  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;
  int   load_cap      = 0;
  int   words_sent    = 0;
  int   hold_left     = 0;
  logic stall_request = 1'b0;
  logic stall_seen    = 1'b0;

  command_stream_inline_load_parser_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (stall_request != stall_seen) begin
      stall_seen = stall_request;
      hold_left  = 150;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.match_beat(out_tuser, out_tdata, out_tlast);
  end

  // Offer one word; returns at the falling edge after it was accepted
  task automatic put_word(input logic [31:0] w, input logic region, input logic fin);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= region;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    sb.take_word(w, region, fin);
    words_sent++;
    @(negedge clk);
  endtask

  // Random payload words for whatever header the parser just took
  task automatic drain_payload();
    while (sb.words_left > 0)
      put_word($urandom, 1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic send_group(input logic [2:0] opc, input logic [12:0] cnt,
                            input logic [15:0] mth);
    put_word({opc, cnt, mth}, 1'b1, 1'b0);
    drain_payload();
  endtask

  // One random header group: mostly well formed, some rejected headers
  task automatic random_group();
    int          pick;
    int unsigned lim;
    logic [2:0]  opc;
    logic [12:0] cnt;
    logic [15:0] mth;
    logic [31:0] w;
    lim  = sb.limit;
    pick = $urandom_range(0, 99);
    opc  = 3'($urandom_range(1, 4));
    if (pick < 20) begin
      w = $urandom;
      case ($urandom_range(0, 3))
        0: w[31:29] = (w[31:30] == 2'b00) ? 3'd0 : 3'(4 + w[31:30]);
        1: w[28:16] = '0;
        2: begin
          if (lim < 8191) w[28:16] = 13'($urandom_range(lim + 1, 8191));
          else w[28:16] = '0;
        end
        default: ;
      endcase
      // keep accidental long headers out of the run
      if (w[31:29] >= OPC_MIN && w[31:29] <= OPC_MAX && w[28:16] > 16 && w[28:16] <= lim)
        w[31:29] = 3'd0;
      put_word(w, 1'b1, 1'b0);
      drain_payload();
    end else begin
      if (pick < 40) begin
        mth = MTH_ADDR;
        cnt = 13'($urandom_range(1, 4));
      end else if (pick < 60) begin
        mth = MTH_SIZE;
        cnt = 13'($urandom_range(1, 4));
      end else if (pick < 85 && sb.loads < load_cap) begin
        mth = MTH_LOAD;
        cnt = 13'($urandom_range(1, 12));
      end else begin
        mth = 16'($urandom);
        if (mth == MTH_LOAD) mth = 16'h0000;
        cnt = 13'($urandom_range(1, 6));
      end
      if (cnt > lim && lim > 0) cnt = 13'(lim);
      send_group(opc, cnt, mth);
    end
  endtask

  task automatic random_words(input int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) random_group();
  endtask

  // Quiesce the block, then write the count limit
  task automatic write_limit(input logic [12:0] v);
    in_tvalid <= 1'b0;
    while (sb.due_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.limit = 32'(v);
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // sender idles less than receiver
    src_idle_pct  = 21;
    sink_idle_pct = 52;
    load_cap      = 7;

    // address latch with extreme words
    put_word({3'd1, 13'd2, MTH_ADDR}, 1'b1, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    put_word(32'h0000_0001, 1'b0, 1'b0);
    // size and slot latch
    put_word({3'd4, 13'd2, MTH_SIZE}, 1'b1, 1'b0);
    put_word(32'h0000_0000, 1'b1, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    // three-word load, region dropping inside the payload
    put_word({3'd2, 13'd3, MTH_LOAD}, 1'b1, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b0, 1'b0);
    put_word(32'h0000_0000, 1'b1, 1'b0);
    put_word(32'h5A5A_A5A5, 1'b0, 1'b0);
    // rejected headers: opcode zero, opcode seven, zero count, count over limit
    put_word({3'd0, 13'd1, MTH_LOAD}, 1'b1, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    put_word({3'd3, 13'd0, MTH_ADDR}, 1'b1, 1'b0);
    put_word({3'd1, 13'd201, MTH_SIZE}, 1'b1, 1'b0);
    // one-word address header latches nothing
    put_word({3'd1, 13'd1, MTH_ADDR}, 1'b1, 1'b0);
    put_word(32'h1234_5678, 1'b1, 1'b0);
    // unknown method
    put_word({3'd3, 13'd1, 16'h0000}, 1'b1, 1'b0);
    put_word(32'hDEAD_BEEF, 1'b0, 1'b0);
    // one-word load
    put_word({3'd4, 13'd1, MTH_LOAD}, 1'b1, 1'b0);
    put_word(32'hC001_D00D, 1'b1, 1'b0);
    // address header longer than two words
    put_word({3'd2, 13'd3, MTH_ADDR}, 1'b1, 1'b0);
    put_word(32'h8000_0000, 1'b1, 1'b0);
    put_word(32'h7FFF_FFFF, 1'b1, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b1, 1'b0);

    random_words(300);

    // zero limit: every header rejected
    write_limit(13'd0);
    random_words(40);

    // sender idles more than receiver
    src_idle_pct  = 52;
    sink_idle_pct = 21;
    load_cap      = 11;
    write_limit(13'd8191);
    // long receiver hold-off during a load longer than MAX_DWORDS
    stall_request = ~stall_request;
    send_group(3'd2, 13'd260, MTH_LOAD);
    random_words(200);

    write_limit(13'd1);
    random_words(60);

    // no idling on either side
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_cap      = 15;
    write_limit(13'd12);
    random_words(250);

    // load cut short by the last ring word: payload beat plus summary
    put_word({3'd1, 13'd5, MTH_LOAD}, 1'b1, 1'b0);
    put_word($urandom, 1'b1, 1'b0);
    put_word($urandom, 1'b1, 1'b1);
    // words after the scan ended give nothing
    repeat (6) put_word($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    in_tvalid <= 1'b0;

    for (int k = 0; k < 20000 && sb.due_beats.size() != 0; k++) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.due_beats.size() != 0)
      $display("%0t: %0d expected beats never arrived", $time, sb.due_beats.size());
    if (sb.mismatches == 0 && sb.due_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("%0t: timeout", $time);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== command_stream_inline_load_parser_core.f =====
sv/csilp_pkg.sv
sv/csilp_parse.sv
sv/csilp_obuf.sv
sv/command_stream_inline_load_parser_core.sv
sv/csilp_checker.sv
tb/command_stream_inline_load_parser_core_test.sv
